FILE: src/hrhp_pkg.sv
// Shared types, constants and the helper function of the HTTP response header parser.
package hrhp_pkg;

	localparam int HEADER_COUNT_MAX_DEF = 255;
	localparam int HEAD_BYTES_MAX_DEF   = 65535;
	localparam int QUEUE_DEPTH_DEF      = 4;

	localparam logic [2:0] KIND_OK      = 3'd0;
	localparam logic [2:0] KIND_VERSION = 3'd1;
	localparam logic [2:0] KIND_STATUS  = 3'd2;
	localparam logic [2:0] KIND_REASON  = 3'd3;
	localparam logic [2:0] KIND_HEADER  = 3'd4;
	localparam logic [2:0] KIND_TRUNC   = 3'd5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [3:0] LEN_NAME_SIZE = 4'd14;

	localparam logic [9:0]  STATUS_SAT = 10'd999;
	localparam logic [31:0] VALUE_SAT  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_flag;
		logic       end_flag;
	} hrhp_byte_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [9:0]  status_value;
		logic [31:0] body_length;
		logic [7:0]  header_total;
		logic [15:0] head_bytes;
	} hrhp_result_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_flag;
		logic       end_flag;
		logic       is_digit;
		logic       is_space;
		logic       is_cr;
		logic       is_lf;
		logic       is_colon;
		logic [3:0] digit;
	} hrhp_cls_t;

	typedef struct packed {
		logic      valid;
		hrhp_cls_t item;
	} hrhp_queue_t;

	function automatic logic [7:0] len_name_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = 8'h43;
			4'd1:    c = 8'h6F;
			4'd2:    c = 8'h6E;
			4'd3:    c = 8'h74;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h6E;
			4'd6:    c = 8'h74;
			4'd7:    c = 8'h2D;
			4'd8:    c = 8'h4C;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h6E;
			4'd11:   c = 8'h67;
			4'd12:   c = 8'h74;
			4'd13:   c = 8'h68;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: src/hrhp_front.sv
// Front end: accepts bytes, classifies them and queues them for the parser.
module hrhp_front #(
	parameter int QUEUE_DEPTH = hrhp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_stall,
	input  hrhp_pkg::hrhp_byte_t     byte_data,
	output hrhp_pkg::hrhp_queue_t    head,
	input  logic                     pop
);
	import hrhp_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

	hrhp_cls_t      mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	hrhp_cls_t      cls;
	logic           push;
	logic           pop_ok;

	always_comb begin
		cls.data_byte  = byte_data.data_byte;
		cls.start_flag = byte_data.start_flag;
		cls.end_flag   = byte_data.end_flag;
		cls.is_digit   = (byte_data.data_byte >= CH_ZERO) && (byte_data.data_byte <= CH_NINE);
		cls.is_space   = byte_data.data_byte == CH_SPACE;
		cls.is_cr      = byte_data.data_byte == CH_CR;
		cls.is_lf      = byte_data.data_byte == CH_LF;
		cls.is_colon   = byte_data.data_byte == CH_COLON;
		cls.digit      = byte_data.data_byte[3:0];
	end

	assign byte_stall = count_q == FULL;
	assign push       = byte_valid && !byte_stall;
	assign pop_ok     = pop && (count_q != '0);

	assign head = '{valid: (count_q != '0), item: mem_q[rd_ptr_q]};

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("queue count exceeds depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(arst_n && push && !pop_ok) |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("queue count did not grow on push");
`endif

endmodule

FILE: src/hrhp_back.sv
// Back end: parser state machine, counters and the result register.
module hrhp_back #(
	parameter int HEADER_COUNT_MAX = hrhp_pkg::HEADER_COUNT_MAX_DEF,
	parameter int HEAD_BYTES_MAX   = hrhp_pkg::HEAD_BYTES_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hrhp_pkg::hrhp_queue_t  head,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output hrhp_pkg::hrhp_result_t result_data
);
	import hrhp_pkg::*;

	localparam int HCW = $clog2(HEADER_COUNT_MAX + 1);
	localparam int BCW = $clog2(HEAD_BYTES_MAX + 1);
	localparam logic [HCW-1:0] HCNT_MAX = HCW'(HEADER_COUNT_MAX);
	localparam logic [BCW-1:0] BCNT_MAX = BCW'(HEAD_BYTES_MAX);

	typedef enum logic [11:0] {
		PH_IDLE     = 12'b0000_0000_0001,
		PH_VERSION  = 12'b0000_0000_0010,
		PH_STATUS   = 12'b0000_0000_0100,
		PH_REASON   = 12'b0000_0000_1000,
		PH_REASON_LF= 12'b0000_0001_0000,
		PH_LINE     = 12'b0000_0010_0000,
		PH_END_LF   = 12'b0000_0100_0000,
		PH_NAME     = 12'b0000_1000_0000,
		PH_SPACE    = 12'b0001_0000_0000,
		PH_VALUE    = 12'b0010_0000_0000,
		PH_VALUE_LF = 12'b0100_0000_0000,
		PH_DONE     = 12'b1000_0000_0000
	} phase_t;

	phase_t          phase_q;
	logic            tok_q;
	logic [3:0]      midx_q;
	logic            mstill_q;
	logic [31:0]     vacc_q;
	logic            vall_q;
	logic [9:0]      sacc_q;
	logic [31:0]     len_q;
	logic [HCW-1:0]  hcnt_q;
	logic [BCW-1:0]  bcnt_q;
	logic            out_valid_q;
	hrhp_result_t    out_data_q;

	hrhp_cls_t       it;
	phase_t          e_phase;
	logic            e_tok;
	logic [3:0]      e_midx;
	logic            e_mstill;
	logic [31:0]     e_vacc;
	logic            e_vall;
	logic [9:0]      e_sacc;
	logic [31:0]     e_len;
	logic [HCW-1:0]  e_hcnt;
	logic [BCW-1:0]  e_bcnt;

	phase_t          n_phase;
	logic            n_tok;
	logic [3:0]      n_midx;
	logic            n_mstill;
	logic [31:0]     n_vacc;
	logic            n_vall;
	logic [9:0]      n_sacc;
	logic [31:0]     n_len;
	logic [HCW-1:0]  n_hcnt;
	logic [BCW-1:0]  n_bcnt;
	logic            n_has;
	logic [2:0]      n_kind;

	logic [13:0]     s_mul;
	logic [35:0]     v_mul;
	logic [31:0]     hcnt_wide;
	logic [31:0]     bcnt_wide;

	assign it  = head.item;
	assign pop = head.valid && (!out_valid_q || !result_stall);

	always_comb begin
		if (it.start_flag) begin
			e_phase  = PH_VERSION;
			e_tok    = 1'b0;
			e_midx   = '0;
			e_mstill = 1'b1;
			e_vacc   = '0;
			e_vall   = 1'b1;
			e_sacc   = '0;
			e_len    = '0;
			e_hcnt   = '0;
			e_bcnt   = '0;
		end else begin
			e_phase  = phase_q;
			e_tok    = tok_q;
			e_midx   = midx_q;
			e_mstill = mstill_q;
			e_vacc   = vacc_q;
			e_vall   = vall_q;
			e_sacc   = sacc_q;
			e_len    = len_q;
			e_hcnt   = hcnt_q;
			e_bcnt   = bcnt_q;
		end
	end

	assign s_mul = ({4'b0, e_sacc} << 3) + ({4'b0, e_sacc} << 1) + {10'b0, it.digit};
	assign v_mul = ({4'b0, e_vacc} << 3) + ({4'b0, e_vacc} << 1) + {32'b0, it.digit};

	always_comb begin
		n_phase  = e_phase;
		n_tok    = e_tok;
		n_midx   = e_midx;
		n_mstill = e_mstill;
		n_vacc   = e_vacc;
		n_vall   = e_vall;
		n_sacc   = e_sacc;
		n_len    = e_len;
		n_hcnt   = e_hcnt;
		n_bcnt   = e_bcnt;
		n_has    = 1'b0;
		n_kind   = KIND_OK;
		if (e_phase != PH_IDLE && e_phase != PH_DONE) begin
			if (e_bcnt < BCNT_MAX) begin
				n_bcnt = e_bcnt + 1'b1;
			end
			unique case (e_phase)
				PH_VERSION: begin
					if (it.is_space) begin
						if (!e_tok) begin
							n_has  = 1'b1;
							n_kind = KIND_VERSION;
						end else begin
							n_phase = PH_STATUS;
						end
					end else begin
						n_tok = 1'b1;
					end
				end
				PH_STATUS: begin
					if (it.is_digit) begin
						n_sacc = (s_mul > 14'(STATUS_SAT)) ? STATUS_SAT : s_mul[9:0];
					end else if (it.is_space) begin
						n_tok   = 1'b0;
						n_phase = PH_REASON;
					end else begin
						n_has  = 1'b1;
						n_kind = KIND_STATUS;
					end
				end
				PH_REASON: begin
					if (it.is_cr) begin
						if (!e_tok) begin
							n_has  = 1'b1;
							n_kind = KIND_REASON;
						end else begin
							n_phase = PH_REASON_LF;
						end
					end else begin
						n_tok = 1'b1;
					end
				end
				PH_REASON_LF: begin
					if (!it.is_lf) begin
						n_has  = 1'b1;
						n_kind = KIND_REASON;
					end else begin
						n_phase = PH_LINE;
					end
				end
				PH_LINE: begin
					if (it.is_cr) begin
						n_phase = PH_END_LF;
					end else if (it.is_colon) begin
						n_has  = 1'b1;
						n_kind = KIND_HEADER;
					end else begin
						n_tok    = 1'b1;
						n_midx   = 4'd1;
						n_mstill = it.data_byte == len_name_char(4'd0);
						n_vacc   = '0;
						n_vall   = 1'b1;
						n_phase  = PH_NAME;
					end
				end
				PH_NAME: begin
					if (it.is_colon) begin
						n_phase = PH_SPACE;
					end else if (e_midx < LEN_NAME_SIZE) begin
						if (it.data_byte != len_name_char(e_midx)) begin
							n_mstill = 1'b0;
						end
						n_midx = e_midx + 1'b1;
					end else begin
						n_mstill = 1'b0;
					end
				end
				PH_SPACE: begin
					if (!it.is_space) begin
						n_has  = 1'b1;
						n_kind = KIND_HEADER;
					end else begin
						n_tok   = 1'b0;
						n_phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (it.is_cr) begin
						if (!e_tok) begin
							n_has  = 1'b1;
							n_kind = KIND_HEADER;
						end else begin
							n_phase = PH_VALUE_LF;
						end
					end else begin
						n_tok = 1'b1;
						if (e_vall && it.is_digit) begin
							n_vacc = (v_mul[35:32] != 4'd0) ? VALUE_SAT : v_mul[31:0];
						end else begin
							n_vall = 1'b0;
							n_vacc = '0;
						end
					end
				end
				PH_VALUE_LF: begin
					if (!it.is_lf) begin
						n_has  = 1'b1;
						n_kind = KIND_HEADER;
					end else begin
						if (e_mstill && e_midx == LEN_NAME_SIZE) begin
							n_len = e_vall ? e_vacc : '0;
						end
						if (e_hcnt < HCNT_MAX) begin
							n_hcnt = e_hcnt + 1'b1;
						end
						n_phase = PH_LINE;
					end
				end
				PH_END_LF: begin
					n_has = 1'b1;
					if (!it.is_lf) begin
						n_kind = KIND_HEADER;
					end else begin
						n_kind = KIND_OK;
					end
				end
				default: begin
					n_phase = e_phase;
				end
			endcase
			if (!n_has && it.end_flag) begin
				n_has  = 1'b1;
				n_kind = KIND_TRUNC;
			end
			if (n_has) begin
				n_phase = PH_DONE;
			end
		end
	end

	assign hcnt_wide = 32'(n_hcnt);
	assign bcnt_wide = 32'(n_bcnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tok_q       <= 1'b0;
			midx_q      <= '0;
			mstill_q    <= 1'b1;
			vacc_q      <= '0;
			vall_q      <= 1'b1;
			sacc_q      <= '0;
			len_q       <= '0;
			hcnt_q      <= '0;
			bcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q  <= n_phase;
				tok_q    <= n_tok;
				midx_q   <= n_midx;
				mstill_q <= n_mstill;
				vacc_q   <= n_vacc;
				vall_q   <= n_vall;
				sacc_q   <= n_sacc;
				len_q    <= n_len;
				hcnt_q   <= n_hcnt;
				bcnt_q   <= n_bcnt;
			end
			if (pop && n_has) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && n_has) begin
			out_data_q.result_kind  <= n_kind;
			out_data_q.status_value <= n_sacc;
			out_data_q.body_length  <= n_len;
			out_data_q.header_total <= hcnt_wide[7:0];
			out_data_q.head_bytes   <= bcnt_wide[15:0];
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_data_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!out_valid_q || !result_stall))
		else $error("parser advanced while a result was held");
	a_status_sat: assert property (@(posedge clk) disable iff (!arst_n)
		sacc_q <= STATUS_SAT)
		else $error("status accumulator above saturation");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(arst_n && pop && n_has) |=> result_valid)
		else $error("result not presented after terminating byte");
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_data.result_kind <= KIND_TRUNC))
		else $error("result kind out of range");
	a_hcnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q <= HCNT_MAX)
		else $error("header counter above saturation");
`endif

endmodule

FILE: src/http_response_header_parser_top.sv
// Top level of the HTTP response header parser.
//
//   channel   direction  handshake                    payload
//   byte      in         byte_valid / byte_stall      byte_data   (hrhp_byte_t)
//   result    out        result_valid / result_stall  result_data (hrhp_result_t)
//
// One byte request is accepted per cycle while the queue has room; the parser state
// machine handles one byte per cycle unless a held result stalls it, so throughput
// is one byte per clock when nothing stalls. A result is registered after its final
// byte is accepted: queue write, then parse. The byte side stalls only when the
// QUEUE_DEPTH entry queue is full, which happens while a result waits on result_stall.
// Reset puts the parser in its idle phase and empties the queue and result register.
module http_response_header_parser_top #(
	parameter int HEADER_COUNT_MAX = hrhp_pkg::HEADER_COUNT_MAX_DEF,
	parameter int HEAD_BYTES_MAX   = hrhp_pkg::HEAD_BYTES_MAX_DEF,
	parameter int QUEUE_DEPTH      = hrhp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  hrhp_pkg::hrhp_byte_t   byte_data,
	output logic                   result_valid,
	input  logic                   result_stall,
	output hrhp_pkg::hrhp_result_t result_data
);
	import hrhp_pkg::*;

	hrhp_queue_t head;
	logic        pop;

	hrhp_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.head       (head),
		.pop        (pop)
	);

	hrhp_back #(
		.HEADER_COUNT_MAX(HEADER_COUNT_MAX),
		.HEAD_BYTES_MAX  (HEAD_BYTES_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

FILE: tb/tb.sv
// Testbench of the HTTP response header parser: directed and random response heads checked against a model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hrhp_pkg::*;

	typedef enum logic [11:0] {
		P_IDLE      = 12'b0000_0000_0001,
		P_VERSION   = 12'b0000_0000_0010,
		P_STATUS    = 12'b0000_0000_0100,
		P_REASON    = 12'b0000_0000_1000,
		P_REASON_LF = 12'b0000_0001_0000,
		P_LINE      = 12'b0000_0010_0000,
		P_END_LF    = 12'b0000_0100_0000,
		P_NAME      = 12'b0000_1000_0000,
		P_SPACE     = 12'b0001_0000_0000,
		P_VALUE     = 12'b0010_0000_0000,
		P_VALUE_LF  = 12'b0100_0000_0000,
		P_DONE      = 12'b1000_0000_0000
	} parse_phase_t;

	typedef struct {
		hrhp_byte_t  item;
		int unsigned gap;
	} queued_byte_t;

	localparam logic [8*14-1:0] LENGTH_NAME = "Content-Length";
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_BYTES = 850;
	localparam int MIN_HEADS    = 20;

	logic         clk          = 1'b0;
	logic         arst_n       = 1'b0;
	logic         byte_valid   = 1'b0;
	logic         byte_stall;
	hrhp_byte_t   byte_data    = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	hrhp_result_t result_data;

	queued_byte_t byte_backlog[$];
	hrhp_result_t head_results[$];
	logic [7:0]   head_text[$];
	int unsigned  fed_bytes = 0;
	int unsigned  gap_count = 0;
	int unsigned  mismatches = 0;
	int unsigned  run_cycles = 0;
	int unsigned  side_cycles = 0;
	int unsigned  hold_left = 0;
	int unsigned  stretch_left = 0;
	bit           stretch_stall = 1'b0;

	parse_phase_t cur_phase      = P_IDLE;
	logic         field_seen     = 1'b0;
	logic [3:0]   name_pos       = 4'd0;
	logic         name_is_length = 1'b1;
	logic [31:0]  value_acc      = '0;
	logic         value_digits   = 1'b1;
	logic [9:0]   status_acc     = '0;
	logic [31:0]  length_reg     = '0;
	logic [7:0]   hdr_lines      = '0;
	logic [15:0]  byte_count     = '0;

	http_response_header_parser_top dut (
		.clk,
		.arst_n,
		.byte_valid,
		.byte_stall,
		.byte_data,
		.result_valid,
		.result_stall,
		.result_data
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] length_char(logic [3:0] pos);
		return LENGTH_NAME[8 * (13 - int'(pos)) +: 8];
	endfunction

	function automatic bit parse_head_byte(input hrhp_byte_t in_b, output hrhp_result_t res);
		logic [7:0]  c;
		logic [7:0]  d;
		logic        is_digit;
		logic [63:0] wide;
		bit          hit;
		logic [2:0]  kind;
		c = in_b.data_byte;
		d = c - CH_ZERO;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		hit = 1'b0;
		kind = KIND_OK;
		res = '0;
		if (in_b.start_flag) begin
			field_seen = 1'b0;
			name_pos = 4'd0;
			name_is_length = 1'b1;
			value_acc = '0;
			value_digits = 1'b1;
			status_acc = '0;
			length_reg = '0;
			hdr_lines = '0;
			byte_count = '0;
			cur_phase = P_VERSION;
		end
		if (cur_phase == P_IDLE || cur_phase == P_DONE)
			return 1'b0;
		if (byte_count < HEAD_BYTES_MAX_DEF)
			byte_count++;
		case (cur_phase)
			P_VERSION: begin
				if (c == CH_SPACE) begin
					if (!field_seen) begin
						hit = 1'b1;
						kind = KIND_VERSION;
					end else
						cur_phase = P_STATUS;
				end else
					field_seen = 1'b1;
			end
			P_STATUS: begin
				if (is_digit) begin
					wide = 64'(status_acc) * 64'd10 + 64'(d);
					status_acc = (wide > 64'd999) ? STATUS_SAT : wide[9:0];
				end else if (c == CH_SPACE) begin
					field_seen = 1'b0;
					cur_phase = P_REASON;
				end else begin
					hit = 1'b1;
					kind = KIND_STATUS;
				end
			end
			P_REASON: begin
				if (c == CH_CR) begin
					if (!field_seen) begin
						hit = 1'b1;
						kind = KIND_REASON;
					end else
						cur_phase = P_REASON_LF;
				end else
					field_seen = 1'b1;
			end
			P_REASON_LF: begin
				if (c != CH_LF) begin
					hit = 1'b1;
					kind = KIND_REASON;
				end else
					cur_phase = P_LINE;
			end
			P_LINE: begin
				if (c == CH_CR)
					cur_phase = P_END_LF;
				else if (c == CH_COLON) begin
					hit = 1'b1;
					kind = KIND_HEADER;
				end else begin
					field_seen = 1'b1;
					name_pos = 4'd1;
					name_is_length = (c == length_char(4'd0));
					value_acc = '0;
					value_digits = 1'b1;
					cur_phase = P_NAME;
				end
			end
			P_NAME: begin
				if (c == CH_COLON)
					cur_phase = P_SPACE;
				else if (name_pos < LEN_NAME_SIZE) begin
					if (c != length_char(name_pos))
						name_is_length = 1'b0;
					name_pos++;
				end else
					name_is_length = 1'b0;
			end
			P_SPACE: begin
				if (c != CH_SPACE) begin
					hit = 1'b1;
					kind = KIND_HEADER;
				end else begin
					field_seen = 1'b0;
					cur_phase = P_VALUE;
				end
			end
			P_VALUE: begin
				if (c == CH_CR) begin
					if (!field_seen) begin
						hit = 1'b1;
						kind = KIND_HEADER;
					end else
						cur_phase = P_VALUE_LF;
				end else begin
					field_seen = 1'b1;
					if (value_digits && is_digit) begin
						wide = 64'(value_acc) * 64'd10 + 64'(d);
						value_acc = (wide > 64'hFFFF_FFFF) ? VALUE_SAT : wide[31:0];
					end else begin
						value_digits = 1'b0;
						value_acc = '0;
					end
				end
			end
			P_VALUE_LF: begin
				if (c != CH_LF) begin
					hit = 1'b1;
					kind = KIND_HEADER;
				end else begin
					if (name_is_length && name_pos == LEN_NAME_SIZE)
						length_reg = value_digits ? value_acc : 32'd0;
					if (hdr_lines < HEADER_COUNT_MAX_DEF)
						hdr_lines++;
					cur_phase = P_LINE;
				end
			end
			P_END_LF: begin
				hit = 1'b1;
				kind = (c != CH_LF) ? KIND_HEADER : KIND_OK;
			end
			default: begin
			end
		endcase
		if (!hit && in_b.end_flag) begin
			hit = 1'b1;
			kind = KIND_TRUNC;
		end
		if (!hit)
			return 1'b0;
		cur_phase = P_DONE;
		res.result_kind = kind;
		res.status_value = status_acc;
		res.body_length = length_reg;
		res.header_total = hdr_lines;
		res.head_bytes = byte_count;
		return 1'b1;
	endfunction

	function automatic logic [7:0] any_byte_but(logic [7:0] a, logic [7:0] b);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == a || c == b);
		return c;
	endfunction

	function automatic int unsigned pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_byte(logic [7:0] b, bit s, bit e, int unsigned gap);
		queued_byte_t q;
		q.item.data_byte = b;
		q.item.start_flag = s;
		q.item.end_flag = e;
		q.gap = gap;
		byte_backlog.push_back(q);
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++)
			head_text.push_back(s[i]);
	endtask

	task automatic add_crlf();
		head_text.push_back(CH_CR);
		head_text.push_back(CH_LF);
	endtask

	task automatic add_field(int n, logic [7:0] a, logic [7:0] b);
		for (int i = 0; i < n; i++)
			head_text.push_back(any_byte_but(a, b));
	endtask

	task automatic send_text(bit with_end, bit burst, bit counted);
		for (int i = 0; i < head_text.size(); i++) begin
			queue_byte(head_text[i], i == 0, with_end && (i == head_text.size() - 1),
				pick_gap(burst));
			if (counted)
				fed_bytes++;
		end
		head_text.delete();
	endtask

	task automatic add_status_line();
		if ($urandom_range(0, 2) == 0)
			add_str("HTTP/1.1");
		else
			add_field($urandom_range(1, 6), CH_SPACE, CH_SPACE);
		head_text.push_back(CH_SPACE);
		repeat ($urandom_range(0, 5))
			head_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		head_text.push_back(CH_SPACE);
		add_field($urandom_range(1, 5), CH_CR, CH_CR);
		add_crlf();
	endtask

	task automatic add_header();
		int r;
		int n;
		r = $urandom_range(0, 9);
		if (r < 4)
			add_str("Content-Length");
		else if (r == 4) begin
			if ($urandom_range(0, 1) == 0)
				add_str("Content-Lengt");
			else begin
				add_str("Content-Length");
				head_text.push_back(any_byte_but(CH_COLON, CH_COLON));
			end
		end else begin
			head_text.push_back(any_byte_but(CH_CR, CH_COLON));
			add_field($urandom_range(0, 5), CH_COLON, CH_COLON);
		end
		head_text.push_back(CH_COLON);
		head_text.push_back(CH_SPACE);
		if (r < 4) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 15) == 0)
					head_text.push_back(any_byte_but(CH_CR, CH_CR));
				else
					head_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
		end else
			add_field($urandom_range(1, 5), CH_CR, CH_CR);
		add_crlf();
	endtask

	task automatic report_mismatch(string what, hrhp_result_t want, hrhp_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%s: expected kind %0d status %0d length %0d headers %0d bytes %0d,",
				" got kind %0d status %0d length %0d headers %0d bytes %0d"},
				what, want.result_kind, want.status_value, want.body_length,
				want.header_total, want.head_bytes, got.result_kind, got.status_value,
				got.body_length, got.header_total, got.head_bytes);
	endtask

	always @(posedge clk or negedge arst_n) begin : byte_side
		logic         next_valid;
		hrhp_byte_t   next_data;
		hrhp_result_t outcome;
		queued_byte_t entry;
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_data <= '0;
		end else begin
			next_valid = byte_valid;
			next_data = byte_data;
			if (byte_valid && !byte_stall) begin
				if (parse_head_byte(byte_data, outcome))
					head_results.push_back(outcome);
				next_valid = 1'b0;
			end
			if (!next_valid && byte_backlog.size() != 0) begin
				if (gap_count < byte_backlog[0].gap)
					gap_count++;
				else begin
					entry = byte_backlog.pop_front();
					gap_count = 0;
					next_data = entry.item;
					next_valid = 1'b1;
				end
			end
			byte_valid <= next_valid;
			byte_data <= next_data;
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_side
		logic         next_stall;
		hrhp_result_t want;
		int           r;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (head_results.size() == 0)
					report_mismatch("unexpected result", '0, result_data);
				else begin
					want = head_results.pop_front();
					if (result_data.result_kind !== want.result_kind ||
						result_data.status_value !== want.status_value ||
						result_data.body_length !== want.body_length ||
						result_data.header_total !== want.header_total ||
						result_data.head_bytes !== want.head_bytes)
						report_mismatch("result mismatch", want, result_data);
				end
			end
			side_cycles++;
			if (hold_left > 0) begin
				hold_left--;
				next_stall = 1'b1;
			end else if (side_cycles == 500 || side_cycles == 2000) begin
				hold_left = HOLD_CYCLES - 1;
				next_stall = 1'b1;
			end else begin
				if (stretch_left == 0) begin
					r = $urandom_range(0, 99);
					if (r < 45) begin
						stretch_stall = 1'b0;
						stretch_left = $urandom_range(1, 15);
					end else if (r < 55) begin
						stretch_stall = 1'b0;
						stretch_left = $urandom_range(60, 200);
					end else if (r < 92) begin
						stretch_stall = 1'b1;
						stretch_left = $urandom_range(1, 3);
					end else begin
						stretch_stall = 1'b1;
						stretch_left = $urandom_range(10, 40);
					end
				end
				stretch_left--;
				next_stall = stretch_stall;
			end
			result_stall <= next_stall;
		end
	end

	always @(posedge clk) begin
		run_cycles <= run_cycles + 1;
		if (run_cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		int         r;
		int         cut;
		int         idx;
		int         responses;
		bit         burst;
		bit         with_end;
		int         marks[$];
		logic [7:0] old;
		responses = 0;

		queue_byte(8'h58, 1'b0, 1'b1, 0);
		add_str("V  R");
		add_crlf();
		add_crlf();
		send_text(1'b1, 1'b0, 1'b1);
		add_str(" ");
		send_text(1'b1, 1'b0, 1'b1);
		add_str("V 2x");
		send_text(1'b0, 1'b0, 1'b1);
		queue_byte(8'h79, 1'b0, 1'b1, 0);
		add_str("V");
		send_text(1'b1, 1'b0, 1'b1);
		add_str("V 1 ");
		head_text.push_back(CH_CR);
		send_text(1'b0, 1'b0, 1'b1);
		add_str("V  R");
		head_text.push_back(CH_CR);
		head_text.push_back(CH_CR);
		send_text(1'b0, 1'b0, 1'b1);

		while (fed_bytes < RANDOM_BYTES || responses < MIN_HEADS) begin
			r = $urandom_range(0, 99);
			burst = ($urandom_range(0, 3) == 0);
			with_end = 1'($urandom_range(0, 1));
			if (r < 10) begin
				repeat ($urandom_range(1, 8)) begin
					queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) < 3,
						$urandom_range(0, 9) < 2, pick_gap(burst));
					fed_bytes++;
				end
			end else begin
				add_status_line();
				repeat ($urandom_range(0, 3))
					add_header();
				add_crlf();
				if (r >= 65) begin
					if (r < 75) begin
						cut = $urandom_range(1, head_text.size());
						while (head_text.size() > cut)
							void'(head_text.pop_back());
						with_end = 1'b1;
					end else if (r < 82) begin
						cut = $urandom_range(1, head_text.size() - 1);
						while (head_text.size() > cut)
							void'(head_text.pop_back());
						with_end = 1'b0;
					end else begin
						marks.delete();
						foreach (head_text[i])
							if (head_text[i] == CH_CR || head_text[i] == CH_LF ||
								head_text[i] == CH_SPACE || head_text[i] == CH_COLON)
								marks.push_back(i);
						if ($urandom_range(0, 1) == 0 && marks.size() != 0)
							idx = marks[$urandom_range(0, marks.size() - 1)];
						else
							idx = $urandom_range(0, head_text.size() - 1);
						old = head_text[idx];
						case ($urandom_range(0, 7))
							0: head_text[idx] = CH_CR;
							1: head_text[idx] = CH_LF;
							2: head_text[idx] = CH_SPACE;
							3: head_text[idx] = CH_COLON;
							default: head_text[idx] = any_byte_but(old, old);
						endcase
					end
				end
				send_text(with_end, burst, 1'b1);
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 2))
						queue_byte(8'($urandom_range(0, 255)), 1'b0,
							1'($urandom_range(0, 1)), pick_gap(burst));
			end
			responses++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_backlog.size() != 0 || byte_valid)
			@(posedge clk);
		while (head_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
src/hrhp_pkg.sv
src/hrhp_front.sv
src/hrhp_back.sv
src/http_response_header_parser_top.sv
tb/tb.sv
